// ===== rtl/low_band_energy_beat_detector_core_defines.svh =====
// Assertion macros shared by the beat detector RTL.
`ifndef LOW_BAND_ENERGY_BEAT_DETECTOR_CORE_DEFINES_SVH
`define LOW_BAND_ENERGY_BEAT_DETECTOR_CORE_DEFINES_SVH

// Same-cycle implication, checked outside reset.
`define LBED_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
	else $error("beat detector assertion failed");

// Next-cycle implication, checked outside reset.
`define LBED_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
	else $error("beat detector assertion failed");

`endif

// ===== rtl/lbed_pkg.sv =====
// Package with widths, register codes and interface types of the beat detector.
`timescale 1ns / 1ps
package lbed_pkg;

	localparam int STRIDE     = 16;
	localparam int MAX_GROUPS = 4096;

	localparam int SAMPLE_W = 16;
	localparam int TIME_W   = 48;
	localparam int LEVEL_W  = 20;
	localparam int IVL_W    = 16;
	localparam int CFG_W    = 20;
	localparam int CFG_IDX_W = 1;

	localparam int FILL_W = $clog2(STRIDE);
	localparam int SUM_W  = SAMPLE_W + FILL_W;
	localparam int CNT_W  = $clog2(MAX_GROUPS + 1);
	localparam int PROD_W = 2 * SUM_W - 1;
	localparam int ACC_W  = PROD_W + CNT_W - 1;
	localparam int SQ_W   = ACC_W + (ACC_W % 2);
	localparam int ROOT_W = SQ_W / 2;
	localparam int REM_W  = ROOT_W + 2;
	localparam int SUB_W  = (REM_W > CNT_W + 1) ? REM_W : CNT_W + 1;
	localparam int STEP_W = $clog2(SQ_W + 1);

	localparam logic [CFG_IDX_W-1:0] REG_RISE_THRESHOLD = 1'b0;
	localparam logic [CFG_IDX_W-1:0] REG_MIN_INTERVAL   = 1'b1;

	typedef struct packed {
		logic             start;
		logic [ACC_W-1:0] dividend;
		logic [CNT_W-1:0] divisor;
	} ds_req_t;

	typedef struct packed {
		logic              done;
		logic [ROOT_W-1:0] root;
	} ds_rsp_t;

endpackage

// ===== rtl/low_band_energy_beat_detector_core.sv =====
// Top level of the low-band energy beat detector.
`timescale 1ns / 1ps
// Low-band energy beat detector. Signed 16-bit samples of one buffer stream in; every run
// of STRIDE samples is summed, the squares of those sums are accumulated, and a trailing
// partial run is dropped. The sample marked tlast ends the buffer: the block then emits one
// transaction with level = floor(sqrt(acc / groups)), a level_valid flag (low when the
// buffer held no full group) and a beat flag. The first valid level only primes the
// previous level; afterwards a beat fires when the level rises by more than rise_threshold
// and more than the minimum beat interval in ms has passed since the last beat (48-bit
// wrapping time). Groups beyond MAX_GROUPS are ignored until the buffer ends. A sample that
// does not close a group leaves the block ready for another; one that closes a group is
// accepted, squared and accumulated before the next sample is taken. A buffer end runs the
// shared compare-subtract unit through 52 division steps and then 26 root steps; a buffer
// with no full group skips both. The result waits in an output register, so the next
// buffer's samples are taken while it is pending; the block stalls only if a second result
// is ready before the first is taken.
`include "low_band_energy_beat_detector_core_defines.svh"
module low_band_energy_beat_detector_core
	import lbed_pkg::*;
(
	input  logic                 clk,
	input  logic                 arst_n,
	// configuration write port
	input  logic                 cfg_we,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [CFG_W-1:0]     cfg_wdata,
	// sample stream
	input  logic                 s_tvalid,
	output logic                 s_tready,
	input  logic [63:0]          s_tdata,   // [15:0] sample, [63:16] time_ms
	input  logic                 s_tlast,   // buffer_end
	// result stream
	output logic                 m_tvalid,
	input  logic                 m_tready,
	output logic [23:0]          m_tdata,   // [0] beat, [20:1] level, [23:21] zero
	output logic                 m_tuser    // [0] level_valid
);

	typedef enum logic [5:0] {
		ST_IDLE   = 6'b000001,
		ST_MUL    = 6'b000010,
		ST_ACC    = 6'b000100,
		ST_FINISH = 6'b001000,
		ST_ROOT   = 6'b010000,
		ST_DECIDE = 6'b100000
	} state_t;

	state_t state_q;

	// configuration
	logic [LEVEL_W-1:0] thr_q;
	logic [IVL_W-1:0]   min_ivl_q;

	// buffer accumulation
	logic signed [SUM_W-1:0] group_sum_q;
	logic [FILL_W-1:0]       fill_q;
	logic [ACC_W-1:0]        acc_q;
	logic [CNT_W-1:0]        count_q;

	// beat history
	logic [LEVEL_W-1:0] prev_q;
	logic               have_prev_q;
	logic [TIME_W-1:0]  last_beat_q;

	// per-item payload
	logic [SUM_W-1:0]   mag_q;
	logic [PROD_W-1:0]  prod_q;
	logic               last_q;
	logic [TIME_W-1:0]  time_q;
	logic [LEVEL_W-1:0] level_res_q;
	logic               valid_res_q;

	// output register
	logic               m_tvalid_q;
	logic               beat_out_q;
	logic [LEVEL_W-1:0] level_out_q;
	logic               valid_out_q;

	ds_req_t ds_req;
	ds_rsp_t ds_rsp;

	logic signed [SAMPLE_W-1:0] in_sample;
	logic [TIME_W-1:0]          in_time;
	logic                       accept;
	logic                       take_sample;
	logic                       group_full;
	logic signed [SUM_W-1:0]    new_sum;
	logic [2*SUM_W-1:0]         square;
	logic                       out_free;
	logic                       rise;
	logic [TIME_W-1:0]          elapsed;
	logic                       beat_c;

	assign in_sample = s_tdata[15:0];
	assign in_time   = s_tdata[63:16];

	assign s_tready    = (state_q == ST_IDLE);
	assign accept      = s_tvalid && s_tready;
	assign take_sample = (count_q < CNT_W'(MAX_GROUPS));
	assign group_full  = (fill_q == FILL_W'(STRIDE - 1));
	assign new_sum     = group_sum_q + SUM_W'(in_sample);
	assign square      = mag_q * mag_q;
	assign out_free    = !m_tvalid_q || m_tready;

	// a falling level never counts as a rise
	assign rise    = (level_res_q > prev_q) && ((level_res_q - prev_q) > thr_q);
	assign elapsed = time_q - last_beat_q;
	assign beat_c  = valid_res_q && have_prev_q && rise && (elapsed > TIME_W'(min_ivl_q));

	assign ds_req.start    = (state_q == ST_FINISH) && (count_q != '0);
	assign ds_req.dividend = acc_q;
	assign ds_req.divisor  = count_q;

	lbed_divsqrt u_divsqrt (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (ds_req),
		.rsp    (ds_rsp)
	);

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			thr_q     <= '0;
			min_ivl_q <= '0;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_RISE_THRESHOLD: thr_q     <= cfg_wdata[LEVEL_W-1:0];
				REG_MIN_INTERVAL:   min_ivl_q <= cfg_wdata[IVL_W-1:0];
				default:            thr_q     <= thr_q;
			endcase
		end
	end

	// sequencer and buffer state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			group_sum_q <= '0;
			fill_q      <= '0;
			acc_q       <= '0;
			count_q     <= '0;
			prev_q      <= '0;
			have_prev_q <= 1'b0;
			last_beat_q <= '0;
			m_tvalid_q  <= 1'b0;
		end else begin
			// load a new result, or drop the one just taken
			if (state_q == ST_DECIDE && out_free) begin
				m_tvalid_q <= 1'b1;
			end else if (m_tready) begin
				m_tvalid_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (accept) begin
						if (take_sample && group_full) begin
							group_sum_q <= '0;
							fill_q      <= '0;
							state_q     <= ST_MUL;
						end else begin
							if (take_sample) begin
								group_sum_q <= new_sum;
								fill_q      <= fill_q + FILL_W'(1);
							end
							state_q <= s_tlast ? ST_FINISH : ST_IDLE;
						end
					end
				end
				ST_MUL: state_q <= ST_ACC;
				ST_ACC: begin
					acc_q   <= acc_q + ACC_W'(prod_q);
					count_q <= count_q + CNT_W'(1);
					state_q <= last_q ? ST_FINISH : ST_IDLE;
				end
				ST_FINISH: state_q <= (count_q != '0) ? ST_ROOT : ST_DECIDE;
				ST_ROOT: begin
					if (ds_rsp.done) begin
						state_q <= ST_DECIDE;
					end
				end
				ST_DECIDE: begin
					// hold until the output register can take the result
					if (out_free) begin
						if (valid_res_q) begin
							prev_q      <= level_res_q;
							have_prev_q <= 1'b1;
						end
						if (beat_c) begin
							last_beat_q <= time_q;
						end
						group_sum_q <= '0;
						fill_q      <= '0;
						acc_q       <= '0;
						count_q     <= '0;
						state_q     <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		if (accept) begin
			last_q <= s_tlast;
			time_q <= in_time;
			// magnitude of the closed group; the most negative sum maps to 2^(SUM_W-1)
			mag_q  <= new_sum[SUM_W-1] ? (~new_sum + SUM_W'(1)) : new_sum;
		end
		if (state_q == ST_MUL) begin
			prod_q <= square[PROD_W-1:0];
		end
		if (state_q == ST_FINISH) begin
			level_res_q <= '0;
			valid_res_q <= 1'b0;
		end
		if (state_q == ST_ROOT && ds_rsp.done) begin
			level_res_q <= ds_rsp.root[LEVEL_W-1:0];
			valid_res_q <= 1'b1;
		end
		if (state_q == ST_DECIDE && out_free) begin
			beat_out_q  <= beat_c;
			level_out_q <= level_res_q;
			valid_out_q <= valid_res_q;
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = {3'b000, level_out_q, beat_out_q};
	assign m_tuser  = valid_out_q;

	`LBED_ASSERT_IMP(a_count_bound, clk, arst_n, 1'b1, count_q <= CNT_W'(MAX_GROUPS))
	`LBED_ASSERT_IMP(a_root_needs_groups, clk, arst_n, state_q == ST_ROOT, count_q != '0)
	`LBED_ASSERT_IMP(a_done_in_root, clk, arst_n, ds_rsp.done, state_q == ST_ROOT)
	`LBED_ASSERT_IMP(a_beat_needs_level, clk, arst_n, m_tvalid_q, !beat_out_q || valid_out_q)
	`LBED_ASSERT_NXT(a_stall_holds_result, clk, arst_n,
		state_q == ST_DECIDE && m_tvalid_q && !m_tready, state_q == ST_DECIDE)

endmodule

// ===== rtl/lbed_divsqrt.sv =====
// Iterative unit: restoring division followed by a digit-by-digit square root.
`timescale 1ns / 1ps
module lbed_divsqrt
	import lbed_pkg::*;
(
	input  logic    clk,
	input  logic    arst_n,
	input  ds_req_t req,
	output ds_rsp_t rsp
);

	typedef enum logic [3:0] {
		PH_IDLE = 4'b0001,
		PH_DIV  = 4'b0010,
		PH_SQRT = 4'b0100,
		PH_DONE = 4'b1000
	} phase_t;

	phase_t             phase_q;
	logic [STEP_W-1:0]  step_q;
	logic [SQ_W-1:0]    num_q;
	logic [SUB_W-1:0]   rem_q;
	logic [ROOT_W-1:0]  root_q;
	logic [CNT_W-1:0]   divisor_q;

	// one compare-subtract serves both the division and the root
	logic [SUB_W-1:0] op_a;
	logic [SUB_W-1:0] op_b;
	logic [SUB_W:0]   diff;
	logic             ge;

	always_comb begin
		if (phase_q == PH_SQRT) begin
			op_a = SUB_W'({rem_q[REM_W-3:0], num_q[SQ_W-1 -: 2]});
			op_b = SUB_W'({root_q, 2'b01});
		end else begin
			op_a = SUB_W'({rem_q[CNT_W-1:0], num_q[SQ_W-1]});
			op_b = SUB_W'(divisor_q);
		end
		diff = {1'b0, op_a} - {1'b0, op_b};
		ge   = ~diff[SUB_W];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_IDLE;
			step_q  <= '0;
		end else begin
			unique case (phase_q)
				PH_IDLE: begin
					if (req.start) begin
						phase_q <= PH_DIV;
						step_q  <= '0;
					end
				end
				PH_DIV: begin
					if (step_q == STEP_W'(SQ_W - 1)) begin
						phase_q <= PH_SQRT;
						step_q  <= '0;
					end else begin
						step_q <= step_q + STEP_W'(1);
					end
				end
				PH_SQRT: begin
					if (step_q == STEP_W'(ROOT_W - 1)) begin
						phase_q <= PH_DONE;
					end else begin
						step_q <= step_q + STEP_W'(1);
					end
				end
				PH_DONE: phase_q <= PH_IDLE;
				default: phase_q <= PH_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		unique case (phase_q)
			PH_IDLE: begin
				num_q     <= SQ_W'(req.dividend);
				divisor_q <= req.divisor;
				rem_q     <= '0;
				root_q    <= '0;
			end
			PH_DIV: begin
				// quotient bits shift in where dividend bits shift out
				num_q <= {num_q[SQ_W-2:0], ge};
				if (step_q == STEP_W'(SQ_W - 1)) begin
					rem_q <= '0;
				end else begin
					rem_q <= ge ? diff[SUB_W-1:0] : op_a;
				end
			end
			PH_SQRT: begin
				num_q  <= {num_q[SQ_W-3:0], 2'b00};
				rem_q  <= ge ? diff[SUB_W-1:0] : op_a;
				root_q <= {root_q[ROOT_W-2:0], ge};
			end
			default: begin
				num_q <= num_q;
			end
		endcase
	end

	assign rsp.done = (phase_q == PH_DONE);
	assign rsp.root = root_q;

endmodule

// ===== test/lbed_checker.sv =====
// Checker for the beat detector: predicts each buffer result and compares it.
`timescale 1ns / 1ps
module lbed_checker
	import lbed_pkg::*;
(
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cfg_we,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [CFG_W-1:0]     cfg_wdata,
	input  logic                 s_tvalid,
	input  logic                 s_tready,
	input  logic [63:0]          s_tdata,   // [15:0] sample, [63:16] time_ms
	input  logic                 s_tlast,   // buffer_end
	input  logic                 m_tvalid,
	input  logic                 m_tready,
	input  logic [23:0]          m_tdata,   // [0] beat, [20:1] level, [23:21] zero
	input  logic                 m_tuser,   // [0] level_valid
	output int                   mismatches,
	output int                   outstanding
);

	typedef struct packed {
		logic               beat;
		logic [LEVEL_W-1:0] level;
		logic               level_valid;
	} buffer_result_t;

	buffer_result_t owed_results[$];

	logic [LEVEL_W-1:0]       rise_thr;
	logic [IVL_W-1:0]         gap_ms;
	logic signed [SUM_W-1:0]  grp_sum;
	logic [FILL_W:0]          grp_fill;
	logic [ACC_W-1:0]         sq_acc;
	logic [CNT_W-1:0]         grp_cnt;
	logic [LEVEL_W-1:0]       prev_lvl;
	logic                     primed;
	logic [TIME_W-1:0]        last_beat_ms;

	// Bitwise root search, one bit per pass from the top.
	function automatic logic [31:0] floor_sqrt(input logic [63:0] v);
		logic [31:0] r;
		logic [63:0] t;
		r = '0;
		for (int b = 31; b >= 0; b--) begin
			t = {32'd0, r | (32'd1 << b)};
			if (t * t <= v)
				r = r | (32'd1 << b);
		end
		return r;
	endfunction

	task automatic check_field(input string name, input int want, input int got);
		if (want != got) begin
			mismatches++;
			$display("%0t: %s expected %0d actual %0d", $time, name, want, got);
		end
	endtask

	task automatic absorb_sample(input logic signed [SAMPLE_W-1:0] smp, input logic last,
			input logic [TIME_W-1:0] now);
		logic signed [SUM_W-1:0] wide;
		logic [SUM_W-1:0]        mag;
		logic [63:0]             mag64;
		logic [LEVEL_W-1:0]      lvl;
		logic [TIME_W-1:0]       elapsed;
		buffer_result_t          res;
		if (grp_cnt < MAX_GROUPS) begin
			wide = SUM_W'(smp);
			grp_sum = grp_sum + wide;
			grp_fill = grp_fill + 1'b1;
			if (grp_fill == STRIDE) begin
				if (grp_sum < 0)
					mag = -grp_sum;
				else
					mag = grp_sum;
				mag64 = mag;
				sq_acc = sq_acc + ACC_W'(mag64 * mag64);
				grp_cnt = grp_cnt + 1'b1;
				grp_sum = '0;
				grp_fill = '0;
			end
		end
		if (last) begin
			res = '0;
			if (grp_cnt != 0) begin
				lvl = LEVEL_W'(floor_sqrt(64'(sq_acc) / 64'(grp_cnt)));
				res.level = lvl;
				res.level_valid = 1'b1;
				if (!primed) begin
					prev_lvl = lvl;
					primed = 1'b1;
				end else begin
					elapsed = now - last_beat_ms;
					if (lvl > prev_lvl && (lvl - prev_lvl) > rise_thr && elapsed > gap_ms) begin
						last_beat_ms = now;
						res.beat = 1'b1;
					end
					prev_lvl = lvl;
				end
			end
			grp_sum = '0;
			grp_fill = '0;
			sq_acc = '0;
			grp_cnt = '0;
			owed_results.push_back(res);
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		buffer_result_t want;
		if (!arst_n) begin
			rise_thr = '0;
			gap_ms = '0;
			grp_sum = '0;
			grp_fill = '0;
			sq_acc = '0;
			grp_cnt = '0;
			prev_lvl = '0;
			primed = 1'b0;
			last_beat_ms = '0;
			owed_results.delete();
			mismatches = 0;
			outstanding = 0;
		end else begin
			if (cfg_we) begin
				case (cfg_index)
					REG_RISE_THRESHOLD: rise_thr = cfg_wdata[LEVEL_W-1:0];
					REG_MIN_INTERVAL:   gap_ms = cfg_wdata[IVL_W-1:0];
					default: ;
				endcase
			end
			if (m_tvalid && m_tready) begin
				if (owed_results.size() == 0) begin
					mismatches++;
					$display("%0t: result with none expected: beat %0b level %0d level_valid %0b",
						$time, m_tdata[0], m_tdata[20:1], m_tuser);
				end else begin
					want = owed_results.pop_front();
					check_field("beat", int'(want.beat), int'(m_tdata[0]));
					check_field("level", int'(want.level), int'(m_tdata[20:1]));
					check_field("level_valid", int'(want.level_valid), int'(m_tuser));
				end
			end
			if (s_tvalid && s_tready)
				absorb_sample(s_tdata[SAMPLE_W-1:0], s_tlast, s_tdata[SAMPLE_W +: TIME_W]);
			outstanding = owed_results.size();
		end
	end

endmodule

// ===== test/tb.sv =====
// Testbench top: drives samples and register writes into the beat detector.
`timescale 1ns / 1ps
module tb
	import lbed_pkg::*;
();

	localparam int WATCHDOG_LIMIT = 4000;  // cycles with no transaction on either side
	localparam int SETTLE_CYCLES  = 120;   // covers the divide and root pass at buffer end
	localparam int PHASES         = 6;
	localparam int PHASE_ITEMS    = 290;
	localparam int PHASE_BUFFERS  = 6;

	// Sample shapes of one buffer.
	localparam int MODE_SILENT     = 0;
	localparam int MODE_QUIET      = 1;
	localparam int MODE_NOISE      = 2;
	localparam int MODE_LOUD       = 3;
	localparam int MODE_FULL_SCALE = 4;

	logic                 clk       = 1'b0;
	logic                 arst_n    = 1'b0;
	logic                 cfg_we    = 1'b0;
	logic [CFG_IDX_W-1:0] cfg_index = '0;
	logic [CFG_W-1:0]     cfg_wdata = '0;
	logic                 s_tvalid  = 1'b0;
	logic                 s_tready;
	logic [63:0]          s_tdata   = '0;
	logic                 s_tlast   = 1'b0;
	logic                 m_tvalid;
	logic                 m_tready  = 1'b0;
	logic [23:0]          m_tdata;
	logic                 m_tuser;

	int                   mismatches;
	int                   outstanding;
	int                   src_idle_pct  = 0;
	int                   snk_stall_pct = 0;
	int                   idle_cycles   = 0;
	logic [TIME_W-1:0]    now_ms        = '0;

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	low_band_energy_beat_detector_core u_top (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_wdata (cfg_wdata),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.s_tlast   (s_tlast),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.m_tuser   (m_tuser)
	);

	lbed_checker u_chk (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_we      (cfg_we),
		.cfg_index   (cfg_index),
		.cfg_wdata   (cfg_wdata),
		.s_tvalid    (s_tvalid),
		.s_tready    (s_tready),
		.s_tdata     (s_tdata),
		.s_tlast     (s_tlast),
		.m_tvalid    (m_tvalid),
		.m_tready    (m_tready),
		.m_tdata     (m_tdata),
		.m_tuser     (m_tuser),
		.mismatches  (mismatches),
		.outstanding (outstanding)
	);

	// Receiver: stall at random with the rate of the current phase.
	always @(negedge clk)
		m_tready <= ($urandom_range(0, 99) >= snk_stall_pct);

	// Watchdog: end the run if no transaction moves on either side for too long.
	always @(posedge clk) begin
		if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= WATCHDOG_LIMIT) begin
			$display("Mismatches found");
			$finish;
		end
	end

	// Write both registers back to back; only called while the block is idle.
	task automatic program_detector(input logic [CFG_W-1:0] thr, input logic [IVL_W-1:0] gap);
		cfg_we <= 1'b1;
		cfg_index <= REG_RISE_THRESHOLD;
		cfg_wdata <= thr;
		@(negedge clk);
		cfg_index <= REG_MIN_INTERVAL;
		cfg_wdata <= CFG_W'(gap);
		@(negedge clk);
		cfg_we <= 1'b0;
	endtask

	// Offer one sample, with random idle cycles ahead of it, and hold it until taken.
	task automatic offer_sample(input logic [SAMPLE_W-1:0] smp, input logic last,
			input logic [TIME_W-1:0] ms);
		while ($urandom_range(0, 99) < src_idle_pct) begin
			s_tvalid <= 1'b0;
			@(negedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata <= {ms, smp};
		s_tlast <= last;
		do @(posedge clk); while (!s_tready);
		@(negedge clk);
	endtask

	// Drop valid and hold off until every owed result has been taken.
	task automatic wait_for_results();
		s_tvalid <= 1'b0;
		@(negedge clk);
		while (outstanding != 0)
			@(negedge clk);
	endtask

	// Drain, then let the block finish any work that owes no result.
	task automatic settle();
		wait_for_results();
		repeat (SETTLE_CYCLES) @(negedge clk);
	endtask

	// Send one buffer of n samples; the last carries tlast and the advanced time.
	task automatic play_buffer(input int n, input int mode);
		int                amp;
		int                v;
		int                r;
		logic              flip;
		logic [SAMPLE_W-1:0] smp;
		// Advance the millisecond clock: mostly small steps, sometimes past the
		// longest interval, now and then a jump anywhere (wraps the 48-bit time).
		r = $urandom_range(0, 99);
		if (r < 70)
			now_ms = now_ms + TIME_W'($urandom_range(0, 200));
		else if (r < 90)
			now_ms = now_ms + TIME_W'($urandom_range(200, 70000));
		else if (r < 97)
			now_ms = {16'($urandom), 32'($urandom)};
		amp = $urandom_range(0, 63);
		flip = 1'b0;
		for (int i = 0; i < n; i++) begin
			if (i % STRIDE == 0)
				flip = 1'($urandom_range(0, 1));
			case (mode)
				MODE_SILENT: v = 0;
				MODE_QUIET:  v = int'($urandom_range(0, 2 * amp)) - amp;
				MODE_NOISE:  v = int'(16'($urandom));
				MODE_LOUD: begin
					// Keep one sign per group so the group sums come out large.
					v = $urandom_range(16384, 32767);
					if (flip)
						v = ($urandom_range(0, 15) == 0) ? -32768 : -v;
				end
				default:     v = ($urandom_range(0, 7) == 0) ? int'(16'($urandom)) : -32768;
			endcase
			smp = SAMPLE_W'(v);
			if (i == n - 1)
				offer_sample(smp, 1'b1, now_ms);
			else
				offer_sample(smp, 1'b0, {16'($urandom), 32'($urandom)});
		end
	endtask

	initial begin
		logic [CFG_W-1:0] thr_tab [PHASES];
		logic [IVL_W-1:0] gap_tab [PHASES];
		int               phase_items;
		int               phase_buffers;
		int               n;
		int               r;

		// Register settings per phase: reset values, the largest level and interval, then mixed ones.
		thr_tab = '{CFG_W'(0), CFG_W'(524288), CFG_W'(1000), CFG_W'(150000), CFG_W'(0),
			CFG_W'(20)};
		gap_tab = '{16'd0, 16'd65535, 16'd0, 16'd300, 16'd0, 16'd65535};
		thr_tab[4] = CFG_W'($urandom_range(0, 524288));
		gap_tab[4] = IVL_W'($urandom_range(0, 65535));

		repeat (4) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);
		program_detector('0, '0);

		// Directed: a lone tlast (empty buffer) at the top of the time range, one
		// full-scale negative group that primes the previous level at time zero,
		// then a buffer of only a partial group, which must leave the state alone.
		offer_sample(16'h7FFF, 1'b1, '1);
		for (int i = 0; i < STRIDE; i++)
			offer_sample(16'h8000, i == STRIDE - 1, '0);
		for (int i = 0; i < 7; i++)
			offer_sample(16'h7FFF, i == 6, (i == 6) ? '0 : {16'($urandom), 32'($urandom)});

		// Random phases, one idling pattern each, new register values at each start.
		for (int p = 0; p < PHASES; p++) begin
			settle();
			program_detector(thr_tab[p], gap_tab[p]);
			case (p % 4)
				0: begin src_idle_pct = 0;  snk_stall_pct = 0;  end
				1: begin src_idle_pct = 53; snk_stall_pct = 0;  end
				2: begin src_idle_pct = 0;  snk_stall_pct = 53; end
				default: begin src_idle_pct = 14; snk_stall_pct = 14; end
			endcase
			phase_items = 0;
			phase_buffers = 0;
			while (phase_items < PHASE_ITEMS || phase_buffers < PHASE_BUFFERS) begin
				// Mostly buffers of a few whole groups, some too short for one group.
				r = $urandom_range(0, 99);
				if (r < 25)
					n = $urandom_range(1, STRIDE - 1);
				else if (r < 90)
					n = $urandom_range(STRIDE, 4 * STRIDE);
				else
					n = $urandom_range(4 * STRIDE + 1, 10 * STRIDE);
				play_buffer(n, $urandom_range(MODE_SILENT, MODE_FULL_SCALE));
				phase_items += n;
				phase_buffers++;
				if ($urandom_range(0, 11) == 0)
					wait_for_results();
			end
		end

		settle();
		if (mismatches == 0)
			$display("No mismatches found");
		else
			$display("Mismatches found");
		$finish;
	end

endmodule
